FILE: rtl/hitr_pkg.sv
// Shared constants, types and helpers for the hue index to RGB pipeline.
package hitr_pkg;

  // Widths fixed by the interface
  localparam int TOT_W = 16;
  localparam int POS_IN_W = 16;
  localparam int CHAR_W = 8;
  localparam int SAT_W = 9;
  localparam int CHAN_W = 8;
  localparam int REG_IDX_W = 2;

  // Tunable constants
  localparam int POSITION_BITS = 16;
  localparam int HUE_FRACTION_BITS = 6;

  localparam int POS_W = (POSITION_BITS < POS_IN_W) ? POSITION_BITS : POS_IN_W;
  localparam logic [POS_IN_W-1:0] POS_MASK = POS_IN_W'((33'd1 << POS_W) - 33'd1);

  // Hue is held in 1/2^HUE_FRACTION_BITS degree units
  localparam int HUE_MAX = 360 << HUE_FRACTION_BITS;
  localparam int HUE_W = $clog2(HUE_MAX);
  localparam int N_W = HUE_W + TOT_W;
  localparam int DIV_STAGES = HUE_W + 2;

  // One sector (60 degrees) in hue units
  localparam int D = 60 << HUE_FRACTION_BITS;
  localparam int D_W = $clog2(D + 1);

  // Channel arithmetic widths; common denominator is 15 * 2^K, and 255/15 = 17
  localparam int C_W = 17;
  localparam int AB_W = 19 + D_W;
  localparam int X_W = C_W + D_W;
  localparam int SUM_W = D_W + 20;
  localparam int K = 19 + HUE_FRACTION_BITS;
  localparam int SCL_W = SUM_W + 5 - K;

  localparam logic [SAT_W-1:0] UNITY = SAT_W'(256);

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [REG_IDX_W-1:0] REG_TOTAL_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SATURATION = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIGHTNESS = 2'd2;

  typedef struct packed {
    logic colored;
    logic out_of_range;
  } flags_t;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic [TOT_W-1:0] rem;
    logic [HUE_W-1:0] num;
    logic [HUE_W-1:0] quo;
    flags_t flags;
  } div_t;

  // One restoring division step: brings in the next dividend bit
  function automatic div_t div_step(div_t d, logic [TOT_W-1:0] tot);
    div_t r;
    logic [TOT_W:0] t;
    r = d;
    t = {d.rem, d.num[HUE_W-1]};
    r.num = {d.num[HUE_W-2:0], 1'b0};
    if (t >= {1'b0, tot}) begin
      r.rem = TOT_W'(t - {1'b0, tot});
      r.quo = {d.quo[HUE_W-2:0], 1'b1};
    end else begin
      r.rem = t[TOT_W-1:0];
      r.quo = {d.quo[HUE_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/hue_index_to_rgb.sv
// Top level: configuration registers and the hue-to-RGB pipeline.
//
//  channel   handshake                    payload
//  -------   ---------------------------  ----------------------------------------
//  item      item_valid / item_ready      position, character
//  result    result_valid / result_ready  red, green, blue, colored, out_of_range
//  config    write_enable (no wait)       write_index, write_data
//
// One word per cycle sustained while result_ready holds. The pipeline is the
// divider, which resolves one hue bit per stage, plus clamp, product, sector,
// multiply, sum and output stages.
// Every stage has its own valid bit and takes a word whenever it is empty or
// its word moves on, so bubbles close up and a stall drops or repeats nothing.
// Synchronous reset empties the pipeline and loads total 1, saturation 1.0,
// lightness 0.5; after any write the derived chroma terms follow through c_cfg, then a_cfg and b_cfg.
module hue_index_to_rgb (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [hitr_pkg::POS_IN_W-1:0]  position,
  input  logic [hitr_pkg::CHAR_W-1:0]    character,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [hitr_pkg::CHAN_W-1:0]    red,
  output logic [hitr_pkg::CHAN_W-1:0]    green,
  output logic [hitr_pkg::CHAN_W-1:0]    blue,
  output logic                           colored,
  output logic                           out_of_range,
  input  logic                           write_enable,
  input  logic [hitr_pkg::REG_IDX_W-1:0] write_index,
  input  logic [hitr_pkg::TOT_W-1:0]     write_data
);

  logic [hitr_pkg::TOT_W-1:0] total_count;
  logic [hitr_pkg::SAT_W-1:0] saturation;
  logic [hitr_pkg::SAT_W-1:0] lightness;
  logic [hitr_pkg::TOT_W-1:0] total_eff;

  logic                       hue_valid;
  logic                       hue_ready;
  logic [hitr_pkg::HUE_W-1:0] hue;
  hitr_pkg::flags_t           flags;

  // config registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= hitr_pkg::TOT_W'(1);
      saturation <= hitr_pkg::SAT_W'(256);
      lightness <= hitr_pkg::SAT_W'(128);
    end else if (write_enable) begin
      unique case (write_index)
        hitr_pkg::REG_TOTAL_COUNT: total_count <= write_data;
        hitr_pkg::REG_SATURATION:  saturation <= write_data[hitr_pkg::SAT_W-1:0];
        hitr_pkg::REG_LIGHTNESS:   lightness <= write_data[hitr_pkg::SAT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero total counts as one
  assign total_eff = (total_count == '0) ? hitr_pkg::TOT_W'(1) : total_count;

  hitr_div u_div (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .position   (position),
    .character  (character),
    .total      (total_eff),
    .hue_valid  (hue_valid),
    .hue_ready  (hue_ready),
    .hue        (hue),
    .flags      (flags)
  );

  hitr_color u_color (
    .clk          (clk),
    .rst          (rst),
    .hue_valid    (hue_valid),
    .hue_ready    (hue_ready),
    .hue          (hue),
    .flags        (flags),
    .saturation   (saturation),
    .lightness    (lightness),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .colored      (colored),
    .out_of_range (out_of_range)
  );

endmodule

FILE: rtl/hitr_div.sv
// Position clamp, hue scaling and pipelined restoring divider for the hue angle.
module hitr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [hitr_pkg::POS_IN_W-1:0] position,
  input  logic [hitr_pkg::CHAR_W-1:0]   character,
  input  logic [hitr_pkg::TOT_W-1:0]    total,
  output logic                          hue_valid,
  input  logic                          hue_ready,
  output logic [hitr_pkg::HUE_W-1:0]    hue,
  output hitr_pkg::flags_t              flags
);

  logic [hitr_pkg::DIV_STAGES-1:0] vld;
  logic [hitr_pkg::DIV_STAGES:0]   rdy;

  logic [hitr_pkg::TOT_W-1:0] pos_q;
  hitr_pkg::flags_t           flags_q;
  hitr_pkg::div_t             div_q [hitr_pkg::HUE_W+1];

  logic [hitr_pkg::POS_IN_W-1:0] pos_m;
  logic [hitr_pkg::TOT_W-1:0]    pos_next;
  hitr_pkg::flags_t              flags_next;
  logic [hitr_pkg::N_W-1:0]      prod;
  hitr_pkg::div_t                div0_next;

  // a stage takes a word when empty or when its word moves on
  always_comb begin
    rdy[hitr_pkg::DIV_STAGES] = hue_ready;
    for (int i = hitr_pkg::DIV_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_comb begin
    pos_m = position & hitr_pkg::POS_MASK;
    flags_next.colored = !(character == hitr_pkg::CHAR_SPACE ||
                           character == hitr_pkg::CHAR_NEWLINE);
    if (pos_m >= total) begin
      pos_next = total - hitr_pkg::TOT_W'(1);
      flags_next.out_of_range = 1'b1;
    end else begin
      pos_next = pos_m;
      flags_next.out_of_range = 1'b0;
    end
  end

  always_comb begin
    prod = hitr_pkg::N_W'(pos_q) * hitr_pkg::N_W'(hitr_pkg::HUE_MAX);
    div0_next.rem = prod[hitr_pkg::N_W-1:hitr_pkg::HUE_W];
    div0_next.num = prod[hitr_pkg::HUE_W-1:0];
    div0_next.quo = '0;
    div0_next.flags = flags_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= item_valid;
      end
      for (int i = 1; i < hitr_pkg::DIV_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pos_q <= pos_next;
      flags_q <= flags_next;
    end
    if (rdy[1]) begin
      div_q[0] <= div0_next;
    end
    for (int k = 1; k <= hitr_pkg::HUE_W; k++) begin
      if (rdy[k+1]) begin
        div_q[k] <= hitr_pkg::div_step(div_q[k-1], total);
      end
    end
  end

  assign item_ready = rdy[0];
  assign hue_valid = vld[hitr_pkg::DIV_STAGES-1];
  assign hue = div_q[hitr_pkg::HUE_W].quo;
  assign flags = div_q[hitr_pkg::HUE_W].flags;

endmodule

FILE: rtl/hitr_color.sv
// Sector split, chroma terms and channel scaling from hue to RGB.
module hitr_color (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        hue_valid,
  output logic                        hue_ready,
  input  logic [hitr_pkg::HUE_W-1:0]  hue,
  input  hitr_pkg::flags_t            flags,
  input  logic [hitr_pkg::SAT_W-1:0]  saturation,
  input  logic [hitr_pkg::SAT_W-1:0]  lightness,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [hitr_pkg::CHAN_W-1:0] red,
  output logic [hitr_pkg::CHAN_W-1:0] green,
  output logic [hitr_pkg::CHAN_W-1:0] blue,
  output logic                        colored,
  output logic                        out_of_range
);

  localparam int NST = 4;

  logic [NST-1:0] vld;
  logic [NST:0]   rdy;

  // terms that follow from the registers alone; c_cfg, then a_cfg and b_cfg, are registered
  logic [hitr_pkg::SAT_W-1:0] s_sat, l_sat, lum_dist, cm;
  logic [hitr_pkg::SAT_W:0]   twol;
  logic [hitr_pkg::C_W-1:0]   c_cfg;
  logic [hitr_pkg::AB_W-1:0]  a_cfg, b_cfg;
  logic [17:0]                l512;

  hitr_pkg::sector_t           sec_next, sec0, sec1;
  logic [hitr_pkg::D_W-1:0]    frac_next, frac0, fsel;
  hitr_pkg::flags_t            flags0, flags1, flags2;
  logic [hitr_pkg::X_W-1:0]    x1;
  logic [hitr_pkg::SUM_W-1:0]  asum, bsum, xsum;
  logic [hitr_pkg::SUM_W-1:0]  rs_next, gs_next, bs_next, rs2, gs2, bs2;

  function automatic logic [hitr_pkg::CHAN_W-1:0] scale(logic [hitr_pkg::SUM_W-1:0] s);
    logic [hitr_pkg::SUM_W+4:0] t;
    logic [hitr_pkg::SCL_W-1:0] v;
    t = {s, 4'b0000} + (hitr_pkg::SUM_W+5)'(s);
    v = t[hitr_pkg::SUM_W+4:hitr_pkg::K];
    if (v > hitr_pkg::SCL_W'(255)) begin
      return 8'hFF;
    end
    return v[hitr_pkg::CHAN_W-1:0];
  endfunction

  always_comb begin
    s_sat = (saturation > hitr_pkg::UNITY) ? hitr_pkg::UNITY : saturation;
    l_sat = (lightness > hitr_pkg::UNITY) ? hitr_pkg::UNITY : lightness;
    twol = {l_sat, 1'b0};
    if (twol >= (hitr_pkg::SAT_W+1)'(256)) begin
      lum_dist = hitr_pkg::SAT_W'(twol - (hitr_pkg::SAT_W+1)'(256));
    end else begin
      lum_dist = hitr_pkg::SAT_W'((hitr_pkg::SAT_W+1)'(256) - twol);
    end
    cm = hitr_pkg::UNITY - lum_dist;
    l512 = {l_sat, 9'b0};
  end

  always_ff @(posedge clk) begin
    c_cfg <= hitr_pkg::C_W'(cm) * hitr_pkg::C_W'(s_sat);
    a_cfg <= hitr_pkg::AB_W'(19'(l512) + 19'(c_cfg)) * hitr_pkg::AB_W'(hitr_pkg::D);
    b_cfg <= hitr_pkg::AB_W'(19'(l512) - 19'(c_cfg)) * hitr_pkg::AB_W'(hitr_pkg::D);
  end

  always_comb begin
    rdy[NST] = result_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  // sector = hue / D by compares against the five sector bounds
  always_comb begin
    sec_next = hitr_pkg::SEC_R_TO_Y;
    frac_next = hitr_pkg::D_W'(hue);
    for (int k = 1; k < 6; k++) begin
      if (hue >= hitr_pkg::HUE_W'(k * hitr_pkg::D)) begin
        sec_next = hitr_pkg::sector_t'(3'(k));
        frac_next = hitr_pkg::D_W'(hue - hitr_pkg::HUE_W'(k * hitr_pkg::D));
      end
    end
  end

  // falling edge of the second component in odd sectors
  always_comb begin
    if (sec0 == hitr_pkg::SEC_Y_TO_G || sec0 == hitr_pkg::SEC_C_TO_B ||
        sec0 == hitr_pkg::SEC_M_TO_R) begin
      fsel = hitr_pkg::D_W'(hitr_pkg::D) - frac0;
    end else begin
      fsel = frac0;
    end
  end

  // A = chroma + offset, B = offset only, X = second component + offset
  always_comb begin
    asum = hitr_pkg::SUM_W'(a_cfg);
    bsum = hitr_pkg::SUM_W'(b_cfg);
    xsum = hitr_pkg::SUM_W'({x1, 1'b0}) + hitr_pkg::SUM_W'(b_cfg);
    unique case (sec1)
      hitr_pkg::SEC_R_TO_Y: begin rs_next = asum; gs_next = xsum; bs_next = bsum; end
      hitr_pkg::SEC_Y_TO_G: begin rs_next = xsum; gs_next = asum; bs_next = bsum; end
      hitr_pkg::SEC_G_TO_C: begin rs_next = bsum; gs_next = asum; bs_next = xsum; end
      hitr_pkg::SEC_C_TO_B: begin rs_next = bsum; gs_next = xsum; bs_next = asum; end
      hitr_pkg::SEC_B_TO_M: begin rs_next = xsum; gs_next = bsum; bs_next = asum; end
      default:              begin rs_next = asum; gs_next = bsum; bs_next = xsum; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= hue_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sec0 <= sec_next;
      frac0 <= frac_next;
      flags0 <= flags;
    end
    if (rdy[1]) begin
      x1 <= hitr_pkg::X_W'(c_cfg) * hitr_pkg::X_W'(fsel);
      sec1 <= sec0;
      flags1 <= flags0;
    end
    if (rdy[2]) begin
      rs2 <= rs_next;
      gs2 <= gs_next;
      bs2 <= bs_next;
      flags2 <= flags1;
    end
    if (rdy[3]) begin
      red <= flags2.colored ? scale(rs2) : '0;
      green <= flags2.colored ? scale(gs2) : '0;
      blue <= flags2.colored ? scale(bs2) : '0;
      colored <= flags2.colored;
      out_of_range <= flags2.out_of_range;
    end
  end

  assign hue_ready = rdy[0];
  assign result_valid = vld[NST-1];

endmodule

FILE: dv/tb.sv
// Self-checking testbench for hue_index_to_rgb: HSL settings, stalls, predicted colors.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 decodes to no register; a write there must leave everything alone
  localparam logic [hitr_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;
  // Pipeline depth from the block's header, plus slack
  localparam int DRAIN_CYCLES = hitr_pkg::HUE_W + 6 + 4;
  localparam int HFB = hitr_pkg::HUE_FRACTION_BITS;

  // One word on the item side: where the character sits and the byte itself
  typedef struct packed {
    logic [hitr_pkg::POS_IN_W-1:0] position;
    logic [hitr_pkg::CHAR_W-1:0]   character;
  } char_word_t;

  // One word on the result side
  typedef struct packed {
    logic [hitr_pkg::CHAN_W-1:0] red;
    logic [hitr_pkg::CHAN_W-1:0] green;
    logic [hitr_pkg::CHAN_W-1:0] blue;
    logic                        colored;
    logic                        out_of_range;
  } color_word_t;

  logic clk;
  logic rst = 1'b1;

  logic                           item_valid = 1'b0;
  logic                           item_ready;
  logic [hitr_pkg::POS_IN_W-1:0]  position = '0;
  logic [hitr_pkg::CHAR_W-1:0]    character = '0;
  logic                           result_valid;
  logic                           result_ready = 1'b0;
  logic [hitr_pkg::CHAN_W-1:0]    red;
  logic [hitr_pkg::CHAN_W-1:0]    green;
  logic [hitr_pkg::CHAN_W-1:0]    blue;
  logic                           colored;
  logic                           out_of_range;
  logic                           write_enable = 1'b0;
  logic [hitr_pkg::REG_IDX_W-1:0] write_index = '0;
  logic [hitr_pkg::TOT_W-1:0]     write_data = '0;

  // Shadow copy of the color registers, loaded with the reset values
  logic [hitr_pkg::TOT_W-1:0] cfg_total = 16'd1;
  logic [hitr_pkg::SAT_W-1:0] cfg_sat = 9'd256;
  logic [hitr_pkg::SAT_W-1:0] cfg_light = 9'd128;

  char_word_t  char_feed[$];       // words not yet offered to the block
  color_word_t pending_colors[$];  // predicted colors, oldest first
  int          error_count = 0;
  bit          no_idle = 1'b0;     // set for the phase that runs without bubbles

  hue_index_to_rgb DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .position     (position),
    .character    (character),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .colored      (colored),
    .out_of_range (out_of_range),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // With a chance of 8 in 100, either side takes a break unless no_idle is set
  function automatic bit take_break();
    return !no_idle && ($urandom_range(99) < 8);
  endfunction

  // (v + m) * 255 over the common denominator, truncated, clamped to a byte
  function automatic logic [7:0] chan_level(longint unsigned vq, longint unsigned mq,
                                            longint unsigned q);
    longint unsigned v;
    v = ((vq + mq) * 255) / q;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Exact integer HSL-to-RGB for one character under the current register values.
  // Everything sits over q = 2^17 * 60 * 2^HFB, so past the hue divide only the last divide truncates.
  function automatic color_word_t hsl_color(logic [15:0] pos_raw, logic [7:0] ch);
    longint unsigned pos, tot, s, l, d, hue, sector, frac, lum_dist, c, x;
    longint unsigned q, cq, xq, mq, rq, gq, bq;
    color_word_t w;
    w = '0;
    pos = pos_raw & hitr_pkg::POS_MASK;
    tot = (cfg_total == 0) ? 1 : cfg_total;   // zero total behaves as one
    if (pos >= tot) begin
      pos = tot - 1;
      w.out_of_range = 1'b1;
    end
    s = (cfg_sat > 256) ? 256 : cfg_sat;      // Q0.8 values saturate at 1.0
    l = (cfg_light > 256) ? 256 : cfg_light;
    d = 60 << HFB;
    hue = ((longint'(360) << HFB) * pos) / tot;
    sector = hue / d;
    frac = hue % d;
    // chroma in 1/65536, second component in 1/(65536*d)
    lum_dist = (2 * l >= 256) ? (2 * l - 256) : (256 - 2 * l);
    c = (256 - lum_dist) * s;
    x = sector[0] ? c * (d - frac) : c * frac;
    q = 131072 * d;
    cq = 2 * c * d;
    xq = 2 * x;
    mq = l * 512 * d - c * d;
    rq = 0;
    gq = 0;
    bq = 0;
    case (hitr_pkg::sector_t'(sector[2:0]))
      hitr_pkg::SEC_R_TO_Y: begin rq = cq; gq = xq; end
      hitr_pkg::SEC_Y_TO_G: begin rq = xq; gq = cq; end
      hitr_pkg::SEC_G_TO_C: begin gq = cq; bq = xq; end
      hitr_pkg::SEC_C_TO_B: begin gq = xq; bq = cq; end
      hitr_pkg::SEC_B_TO_M: begin rq = xq; bq = cq; end
      default: begin rq = cq; bq = xq; end
    endcase
    // space and newline stay black and uncolored; the range flag still shows
    if (ch != hitr_pkg::CHAR_SPACE && ch != hitr_pkg::CHAR_NEWLINE) begin
      w.colored = 1'b1;
      w.red = chan_level(rq, mq, q);
      w.green = chan_level(gq, mq, q);
      w.blue = chan_level(bq, mq, q);
    end
    return w;
  endfunction

  // Item driver: the prediction is taken at the accepting edge, with the payload
  // still on the pins. Valid only drops or moves on once the word has gone in.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) pending_colors.push_back(hsl_color(position, character));
      if (!item_valid || item_ready) begin
        if (char_feed.size() != 0 && !take_break()) begin
          item_valid <= 1'b1;
          position <= char_feed[0].position;
          character <= char_feed[0].character;
          void'(char_feed.pop_front());
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each accepted color against the oldest prediction
  always @(posedge clk) begin : color_check
    color_word_t got;
    color_word_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        got = {red, green, blue, colored, out_of_range};
        if (pending_colors.size() == 0) begin
          if (error_count < 10)
            $display("color word with none predicted: rgb %02h %02h %02h colored %0b oor %0b",
                     got.red, got.green, got.blue, got.colored, got.out_of_range);
          error_count++;
        end else begin
          want = pending_colors.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.colored !== want.colored || got.out_of_range !== want.out_of_range) begin
            if (error_count < 10)
              $display("mismatch: want %02h %02h %02h c%0b o%0b, got %02h %02h %02h c%0b o%0b",
                       want.red, want.green, want.blue, want.colored, want.out_of_range,
                       got.red, got.green, got.blue, got.colored, got.out_of_range);
            error_count++;
          end
        end
      end
      result_ready <= !take_break();
    end
  end

  task automatic add_char(logic [15:0] pos, logic [7:0] ch);
    char_feed.push_back({pos, ch});
  endtask

  // Block until every word is in and every color is out, then let the pipe empty
  task automatic drain();
    while (char_feed.size() != 0 || item_valid) @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Single register write; the shadow copy keeps only the register's own bits
  task automatic cfg_write(logic [hitr_pkg::REG_IDX_W-1:0] idx, logic [15:0] data);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    case (idx)
      hitr_pkg::REG_TOTAL_COUNT: cfg_total = data;
      hitr_pkg::REG_SATURATION: cfg_sat = data[8:0];
      hitr_pkg::REG_LIGHTNESS: cfg_light = data[8:0];
      default: ;
    endcase
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  // New setting for all three registers, then a wait while the chroma terms follow
  task automatic program_hsl(logic [15:0] total, logic [15:0] sat, logic [15:0] light);
    cfg_write(hitr_pkg::REG_TOTAL_COUNT, total);
    cfg_write(hitr_pkg::REG_SATURATION, sat);
    cfg_write(hitr_pkg::REG_LIGHTNESS, light);
    repeat (3) @(posedge clk);
  endtask

  // Q0.8 setting: both ends, values past 1.0, else uniform; junk in the upper bits
  function automatic logic [15:0] pick_q08();
    logic [8:0] v;
    case ($urandom_range(9))
      0: v = 9'd0;
      1: v = 9'd256;
      2: v = 9'($urandom_range(511, 257));
      default: v = 9'($urandom_range(256));
    endcase
    return {7'($urandom), v};
  endfunction

  initial begin : stimulus
    logic [15:0] total;
    int lim;
    logic [15:0] pos;
    logic [7:0] ch;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset setting: one position, so every hue is zero (pure red)
    add_char(16'd0, 8'h41);
    add_char(16'hFFFF, 8'hFF);                   // far past total: clamped, flagged
    add_char(16'd1, hitr_pkg::CHAR_SPACE);       // uncolored, still flagged
    add_char(16'd0, hitr_pkg::CHAR_NEWLINE);
    add_char(16'd0, 8'h00);
    drain();

    // Six positions land one per sector; the seventh is just past the end
    program_hsl(16'd6, 16'd256, 16'd128);
    for (int p = 0; p <= 6; p++) add_char(16'(p), 8'(8'h61 + p));
    drain();

    // Zero total acts as one; saturation 0x1FF clamps to 1.0
    program_hsl(16'd0, 16'hFFFF, 16'h0040);
    add_char(16'd0, 8'h61);
    add_char(16'd5, hitr_pkg::CHAR_NEWLINE);
    add_char(16'h8000, 8'h7E);
    drain();

    // Widest total, no saturation, full lightness: white
    program_hsl(16'hFFFF, 16'd0, 16'h0100);
    add_char(16'hFFFE, 8'h80);
    add_char(16'h7FFF, 8'h01);
    drain();

    // One position per degree; a stray write to the unused index must change nothing
    program_hsl(16'd360, 16'd128, 16'd200);
    cfg_write(REG_SPARE, 16'h0005);
    repeat (3) @(posedge clk);
    add_char(16'd300, 8'h7A);
    add_char(16'd359, 8'h7A);
    add_char(16'd360, 8'h7A);
    drain();

    // Random phases: fresh setting each time, third phase runs without bubbles
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(3))
        0: total = 16'($urandom_range(64, 1));
        1: total = 16'($urandom_range(2000, 65));
        2: total = 16'($urandom);
        default: begin
          case ($urandom_range(2))
            0: total = 16'd0;
            1: total = 16'd1;
            default: total = 16'hFFFF;
          endcase
        end
      endcase
      program_hsl(total, pick_q08(), pick_q08());
      no_idle = (ph == 2);
      lim = (total == 0) ? 1 : total;
      lim = lim + lim / 8 + 1;
      if (lim > 65535) lim = 65535;
      for (int n = 0; n < 80; n++) begin
        // mostly near the valid range with a tail past it, some fully random
        if ($urandom_range(9) == 0) pos = 16'($urandom);
        else pos = 16'($urandom_range(lim, 0));
        if ($urandom_range(9) == 0)
          ch = $urandom_range(1) ? hitr_pkg::CHAR_SPACE : hitr_pkg::CHAR_NEWLINE;
        else
          ch = 8'($urandom_range(255));
        add_char(pos, ch);
      end
      drain();
      no_idle = 1'b0;
    end

    if (error_count == 0 && pending_colors.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hang guard, far beyond any correct run
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
